@@ rtl/core/dpmc_pkg.sv @@
// Shared types, codes and helper functions for the pairwise mutation counter.
// No dependencies; the front end, queue, back end and top level refer to this package by scoped names.
package dpmc_pkg;

    localparam int MAX_SEQS_DEF = 32;
    localparam int MAX_LEN_DEF  = 1024;

    localparam int SEQ_W   = 5;
    localparam int POS_W   = 10;
    localparam int BASE_W  = 8;
    localparam int CNT_W   = 11;
    localparam int MODEL_W = 2;
    localparam int CODE_W  = 3;

    localparam int QUEUE_DEPTH = 2;

    // Stored nucleotide codes.
    localparam logic [CODE_W-1:0] CODE_MISSING = 3'd0;
    localparam logic [CODE_W-1:0] CODE_A       = 3'd1;
    localparam logic [CODE_W-1:0] CODE_C       = 3'd2;
    localparam logic [CODE_W-1:0] CODE_G       = 3'd3;
    localparam logic [CODE_W-1:0] CODE_T       = 3'd4;

    // Lowercase ASCII characters accepted as bases.
    localparam logic [BASE_W-1:0] CHAR_A = 8'h61;
    localparam logic [BASE_W-1:0] CHAR_C = 8'h63;
    localparam logic [BASE_W-1:0] CHAR_G = 8'h67;
    localparam logic [BASE_W-1:0] CHAR_T = 8'h74;

    localparam logic [MODEL_W-1:0] MODEL_NONE     = 2'd0;
    localparam logic [MODEL_W-1:0] MODEL_MISMATCH = 2'd1;
    localparam logic [MODEL_W-1:0] MODEL_TSTV     = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic CFG_IDX_MODEL = 1'b0;
    localparam logic CFG_IDX_LEN   = 1'b1;

    localparam logic [MODEL_W-1:0] MODEL_RESET = MODEL_TSTV;
    localparam logic [CNT_W-1:0]   LEN_RESET   = 11'd1024;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  seq_index;
        logic [POS_W-1:0]  position;
        logic [BASE_W-1:0] base;
        logic [SEQ_W-1:0]  other_index;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_W-1:0] first_seq;
        logic [SEQ_W-1:0] second_seq;
        logic [CNT_W-1:0] common_count;
        logic [CNT_W-1:0] first_count;
        logic [CNT_W-1:0] second_count;
    } t_out_item;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic              query;
        logic [SEQ_W-1:0]  seq_a;
        logic [SEQ_W-1:0]  seq_b;
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] code;
        logic              seq_a_ok;
        logic              seq_b_ok;
        logic              pos_ok;
    } t_cmd;

    function automatic logic [CODE_W-1:0] encode_base(input logic [BASE_W-1:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_MISSING;
        endcase
        return code;
    endfunction

    function automatic logic is_base(input logic [CODE_W-1:0] code);
        return code inside {[CODE_A:CODE_T]};
    endfunction

    function automatic logic is_purine(input logic [CODE_W-1:0] code);
        return (code == CODE_A) || (code == CODE_G);
    endfunction

endpackage

@@ rtl/core/dpmc_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module dpmc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/dpmc_front.sv @@
// Front end: takes input beats, encodes the base byte and checks index ranges.
// Depends on dpmc_pkg.
module dpmc_front #(
    parameter int MAX_SEQS = dpmc_pkg::MAX_SEQS_DEF,
    parameter int MAX_LEN  = dpmc_pkg::MAX_LEN_DEF
) (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dpmc_pkg::t_in_item i_in_item,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output dpmc_pkg::t_cmd     o_cmd
);

    localparam logic [31:0] SEQS_U = MAX_SEQS;
    localparam logic [31:0] LEN_U  = MAX_LEN;

    assign o_cmd_valid = i_in_valid;
    assign o_in_ready  = i_cmd_ready;

    always_comb begin
        o_cmd.query    = (i_in_item.kind == dpmc_pkg::KIND_QUERY);
        o_cmd.seq_a    = i_in_item.seq_index;
        o_cmd.seq_b    = i_in_item.other_index;
        o_cmd.position = i_in_item.position;
        o_cmd.code     = dpmc_pkg::encode_base(i_in_item.base);
        o_cmd.seq_a_ok = 32'(i_in_item.seq_index) < SEQS_U;
        o_cmd.seq_b_ok = 32'(i_in_item.other_index) < SEQS_U;
        o_cmd.pos_ok   = 32'(i_in_item.position) < LEN_U;
    end

endmodule

@@ rtl/core/dpmc_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on dpmc_pkg.
module dpmc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dpmc_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output dpmc_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(dpmc_pkg::QUEUE_DEPTH);

    dpmc_pkg::t_cmd r_mem [dpmc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [PW:0]    r_count;
    logic           push;
    logic           pop;

    assign o_ready = (r_count != (PW+1)'(dpmc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/core/dpmc_back.sv @@
// Back end: holds the configuration and the base store, writes loads and walks
// both sequences of a query one position per cycle. Depends on dpmc_pkg, dpmc_ram.
module dpmc_back #(
    parameter int MAX_SEQS = dpmc_pkg::MAX_SEQS_DEF,
    parameter int MAX_LEN  = dpmc_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [dpmc_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  dpmc_pkg::t_cmd               i_cmd,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dpmc_pkg::t_out_item          o_out_item
);

    localparam int DEPTH = MAX_SEQS * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = dpmc_pkg::CNT_W;
    localparam int SW    = dpmc_pkg::SEQ_W;
    localparam int KW    = dpmc_pkg::CODE_W;
    localparam logic [31:0] LEN_U = MAX_LEN;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [dpmc_pkg::MODEL_W-1:0]  r_model;
    logic [CW-1:0]                 r_len;
    logic [SW-1:0]                 r_seq_a, n_seq_a;
    logic [SW-1:0]                 r_seq_b, n_seq_b;
    logic                          r_ok_a, n_ok_a;
    logic                          r_ok_b, n_ok_b;
    logic [AW-1:0]                 r_addr_a, n_addr_a;
    logic [AW-1:0]                 r_addr_b, n_addr_b;
    logic [CW-1:0]                 r_left, n_left;
    logic                          r_rd_vld, n_rd_vld;
    logic [CW-1:0]                 r_common, n_common;
    logic [CW-1:0]                 r_first, n_first;
    logic [CW-1:0]                 r_second, n_second;
    logic                          r_out_vld, n_out_vld;
    dpmc_pkg::t_out_item           r_out, n_out;

    logic [CW-1:0] eff_len;
    logic          counting;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] base_a;
    logic [AW-1:0] base_b;
    logic [KW-1:0] rdata_a;
    logic [KW-1:0] rdata_b;
    logic [KW-1:0] code_a;
    logic [KW-1:0] code_b;
    logic          out_free;

    // The user must write the configuration only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= dpmc_pkg::MODEL_RESET;
            r_len   <= dpmc_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dpmc_pkg::CFG_IDX_MODEL) begin
                r_model <= i_cfg_data[dpmc_pkg::MODEL_W-1:0];
            end else begin
                r_len <= i_cfg_data;
            end
        end
    end

    assign eff_len  = (32'(r_len) > LEN_U) ? CW'(MAX_LEN) : r_len;
    assign counting = (r_model == dpmc_pkg::MODEL_MISMATCH) ||
                      (r_model == dpmc_pkg::MODEL_TSTV);

    // Row bases of the two sequences; only used when the index is in range.
    assign base_a    = i_cmd.seq_a_ok ? AW'(i_cmd.seq_a) * AW'(MAX_LEN) : '0;
    assign base_b    = i_cmd.seq_b_ok ? AW'(i_cmd.seq_b) * AW'(MAX_LEN) : '0;
    assign ram_waddr = base_a + (i_cmd.pos_ok ? AW'(i_cmd.position) : '0);

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign ram_we      = i_cmd_valid && o_cmd_ready && !i_cmd.query &&
                         i_cmd.seq_a_ok && i_cmd.pos_ok;

    dpmc_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (i_cmd.code),
        .i_raddr_a (r_addr_a),
        .i_raddr_b (r_addr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // A sequence beyond the store reads as all missing.
    assign code_a   = r_ok_a ? rdata_a : dpmc_pkg::CODE_MISSING;
    assign code_b   = r_ok_b ? rdata_b : dpmc_pkg::CODE_MISSING;
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_seq_a   = r_seq_a;
        n_seq_b   = r_seq_b;
        n_ok_a    = r_ok_a;
        n_ok_b    = r_ok_b;
        n_addr_a  = r_addr_a;
        n_addr_b  = r_addr_b;
        n_left    = r_left;
        n_rd_vld  = 1'b0;
        n_common  = r_common;
        n_first   = r_first;
        n_second  = r_second;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;

        // Accumulate the codes read in the previous cycle.
        if (r_rd_vld && dpmc_pkg::is_base(code_a) && dpmc_pkg::is_base(code_b)) begin
            n_common = r_common + CW'(1);
            if (code_a != code_b) begin
                if (r_model == dpmc_pkg::MODEL_MISMATCH ||
                    dpmc_pkg::is_purine(code_a) == dpmc_pkg::is_purine(code_b)) begin
                    n_first = r_first + CW'(1);
                end else begin
                    n_second = r_second + CW'(1);
                end
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.query) begin
                    n_seq_a  = i_cmd.seq_a;
                    n_seq_b  = i_cmd.seq_b;
                    n_ok_a   = i_cmd.seq_a_ok;
                    n_ok_b   = i_cmd.seq_b_ok;
                    n_addr_a = base_a;
                    n_addr_b = base_b;
                    n_left   = eff_len;
                    n_common = '0;
                    n_first  = '0;
                    n_second = '0;
                    if (i_cmd.seq_a == i_cmd.seq_b) begin
                        n_common = eff_len;
                        n_state  = ST_FINISH;
                    end else if (counting && eff_len != '0) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_RUN: begin
                n_rd_vld = 1'b1;
                n_addr_a = r_addr_a + AW'(1);
                n_addr_b = r_addr_b + AW'(1);
                n_left   = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.first_seq    = r_seq_a;
                    n_out.second_seq   = r_seq_b;
                    n_out.common_count = r_common;
                    n_out.first_count  = r_first;
                    n_out.second_count = r_second;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq_a  <= n_seq_a;
        r_seq_b  <= n_seq_b;
        r_ok_a   <= n_ok_a;
        r_ok_b   <= n_ok_b;
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
        r_left   <= n_left;
        r_common <= n_common;
        r_first  <= n_first;
        r_second <= n_second;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_left != '0)
        else $error("position walk running with no positions left");

    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("read data arrived outside a position walk");

    a_counts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ({1'b0, r_out.first_count} + {1'b0, r_out.second_count}
                       <= {1'b0, r_out.common_count}))
        else $error("mutation counts exceed the common count");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == ST_FINISH)
        else $error("result raised outside the finish step");

endmodule

@@ rtl/core/dna_pair_mutation_counter.sv @@
// Top level of the pairwise mutation counter: front end, command queue, back end.
// Depends on dpmc_pkg, dpmc_front, dpmc_queue, dpmc_back.
//
// Input beats are load or query items on a valid/ready channel. A load writes one
// base code into the store; a query compares two stored sequences and yields one
// result beat on the output channel. Loads produce no output.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 model,
// 1 length) at the clock edge; write only while no item is in flight.
// A two-entry queue sits between the front end and the back end, so input beats
// keep being taken while the back end works or a result waits in the output register.
// A counting query passes the run, drain and finish states; in run the back end reads
// one position of both sequences per cycle through the two read ports of the store,
// over the effective length (seq_length capped at MAX_LEN). Self queries, models 0
// and 3 and zero length skip the run and drain states.
// Reset (synchronous, active low) empties the queue and the output register and
// restores model 2 and length 1024; the base store is not cleared and must be
// written before it is read.
// When the receiver stalls, the result holds in the output register, the back end
// waits before presenting the next result, and the queue then fills and drops ready.
module dna_pair_mutation_counter #(
    parameter int MAX_SEQS = dpmc_pkg::MAX_SEQS_DEF,
    parameter int MAX_LEN  = dpmc_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [dpmc_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dpmc_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dpmc_pkg::t_out_item          o_out_item
);

    logic           fe_valid;
    logic           fe_ready;
    dpmc_pkg::t_cmd fe_cmd;
    logic           q_valid;
    logic           q_ready;
    dpmc_pkg::t_cmd q_cmd;

    dpmc_front #(
        .MAX_SEQS (MAX_SEQS),
        .MAX_LEN  (MAX_LEN)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (fe_valid),
        .i_cmd_ready (fe_ready),
        .o_cmd       (fe_cmd)
    );

    dpmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .o_ready (fe_ready),
        .i_cmd   (fe_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    dpmc_back #(
        .MAX_SEQS (MAX_SEQS),
        .MAX_LEN  (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dna_pair_mutation_counter: loads are mirrored into a
// copy of the sequence store kept here, and query results are checked beat by beat.
// Depends on dpmc_pkg and the counter RTL only.
module tb_top;
    import dpmc_pkg::*;

    localparam int NSEQ         = MAX_SEQS_DEF;
    localparam int NLEN         = MAX_LEN_DEF;
    localparam int MAX_GAP      = 6;
    localparam int IDLE_PAD     = 16;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int PREFILL_SEQS = 8;
    localparam int PREFILL_LEN  = 16;
    localparam logic [MODEL_W-1:0] MODEL_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0]   LEN_OVER     = 11'd2047;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [CNT_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_item;

    dna_pair_mutation_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Copy of the sequence store and the two registers.
    logic [CODE_W-1:0]  seq_codes [NSEQ][NLEN];
    bit                 seq_written [NSEQ][NLEN];
    logic [MODEL_W-1:0] model_reg;
    logic [CNT_W-1:0]   len_reg;
    t_out_item          pending_counts [$];

    int n_errors      = 0;
    int results_got   = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int settings_used = 0;
    int cycle_cnt     = 0;
    int stall_cycles  = 0;
    int hold_token    = 0;
    int hold_len      = 0;
    bit tx_idle_en    = 1'b0;
    bit rx_idle_en    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [CODE_W-1:0] base_code(logic [BASE_W-1:0] ch);
        case (ch)
            CHAR_A:  return CODE_A;
            CHAR_C:  return CODE_C;
            CHAR_G:  return CODE_G;
            CHAR_T:  return CODE_T;
            default: return CODE_MISSING;
        endcase
    endfunction

    function automatic t_out_item counts_for_pair(logic [SEQ_W-1:0] s1, logic [SEQ_W-1:0] s2);
        t_out_item         r;
        int                n;
        logic [CODE_W-1:0] x;
        logic [CODE_W-1:0] y;
        logic              x_pur;
        logic              y_pur;
        n = (len_reg > NLEN) ? NLEN : int'(len_reg);
        r = '0;
        r.first_seq  = s1;
        r.second_seq = s2;
        if (s1 == s2) begin
            r.common_count = CNT_W'(n);
        end else if (model_reg == MODEL_MISMATCH || model_reg == MODEL_TSTV) begin
            for (int k = 0; k < n; k++) begin
                x = seq_codes[s1][k];
                y = seq_codes[s2][k];
                if (x < CODE_A || x > CODE_T || y < CODE_A || y > CODE_T)
                    continue;
                r.common_count = r.common_count + 1'b1;
                if (x != y) begin
                    x_pur = (x == CODE_A) || (x == CODE_G);
                    y_pur = (y == CODE_A) || (y == CODE_G);
                    // Same chemical class means a transition.
                    if (model_reg == MODEL_MISMATCH || x_pur == y_pur)
                        r.first_count = r.first_count + 1'b1;
                    else
                        r.second_count = r.second_count + 1'b1;
                end
            end
        end
        return r;
    endfunction

    // True when a query of s1 against s2 reads only entries that were loaded.
    function automatic bit pair_loaded(logic [SEQ_W-1:0] s1, logic [SEQ_W-1:0] s2);
        int n;
        n = (len_reg > NLEN) ? NLEN : int'(len_reg);
        if (s1 == s2 || !(model_reg == MODEL_MISMATCH || model_reg == MODEL_TSTV))
            return 1'b1;
        for (int k = 0; k < n; k++)
            if (!seq_written[s1][k] || !seq_written[s2][k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [BASE_W-1:0] rand_base();
        logic [BASE_W-1:0] picks [4];
        picks = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
        if ($urandom_range(0, 3) != 0)
            return picks[$urandom_range(0, 3)];
        return BASE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [SEQ_W-1:0] pick_seq();
        // Most traffic goes to a few sequences so loads change later answers.
        if ($urandom_range(0, 9) < 7)
            return SEQ_W'($urandom_range(0, 7));
        return SEQ_W'($urandom_range(0, NSEQ - 1));
    endfunction

    function automatic t_in_item load_beat(logic [SEQ_W-1:0] s, logic [POS_W-1:0] p,
                                           logic [BASE_W-1:0] b);
        t_in_item it;
        it.kind        = KIND_LOAD;
        it.seq_index   = s;
        it.position    = p;
        it.base        = b;
        it.other_index = SEQ_W'($urandom_range(0, NSEQ - 1));
        return it;
    endfunction

    // A pair that would read a never-loaded entry is sent as a self query instead.
    function automatic t_in_item query_beat(logic [SEQ_W-1:0] s1, logic [SEQ_W-1:0] s2);
        t_in_item it;
        it.kind        = KIND_QUERY;
        it.seq_index   = s1;
        it.position    = POS_W'($urandom_range(0, NLEN - 1));
        it.base        = BASE_W'($urandom_range(0, 255));
        it.other_index = pair_loaded(s1, s2) ? s2 : s1;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.kind == KIND_LOAD) begin
            seq_codes[it.seq_index][it.position]   = base_code(it.base);
            seq_written[it.seq_index][it.position] = 1'b1;
            loads_sent++;
        end else begin
            pending_counts.push_back(counts_for_pair(it.seq_index, it.other_index));
            queries_sent++;
        end
    endtask

    // Loads give no result, so a fixed pause covers a load still in the pipe.
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAD) @(posedge i_clk);
    endtask

    task automatic set_counter_mode(logic [MODEL_W-1:0] model, logic [CNT_W-1:0] len);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_MODEL;
        i_cfg_data  <= CNT_W'(model);
        @(negedge i_clk);
        i_cfg_index <= CFG_IDX_LEN;
        i_cfg_data  <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_reg = model;
        len_reg   = len;
        settings_used++;
    endtask

    // Load the first positions of the busiest sequences at full rate so pair
    // queries over short lengths always have data to compare.
    task automatic test_prefill();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int s = 0; s < PREFILL_SEQS; s++)
            for (int p = 0; p < PREFILL_LEN; p++)
                send_item(load_beat(SEQ_W'(s), POS_W'(p), rand_base()));
    endtask

    task automatic test_base_codes();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_item(load_beat(5'd10, 10'd0, CHAR_A));
        send_item(load_beat(5'd10, 10'd1, CHAR_C));
        send_item(load_beat(5'd10, 10'd2, CHAR_G));
        send_item(load_beat(5'd10, 10'd3, CHAR_T));
        send_item(load_beat(5'd11, 10'd0, CHAR_G));
        send_item(load_beat(5'd11, 10'd1, CHAR_T));
        send_item(load_beat(5'd11, 10'd2, CHAR_C));
        send_item(load_beat(5'd11, 10'd3, CHAR_A));
        // Uppercase and non-letter bytes must be stored as missing.
        send_item(load_beat(5'd12, 10'd0, 8'h41));
        send_item(load_beat(5'd12, 10'd1, 8'hFF));
        send_item(load_beat(5'd12, 10'd2, 8'h00));
        send_item(load_beat(5'd12, 10'd3, CHAR_C));
        set_counter_mode(MODEL_TSTV, 11'd4);
        send_item(query_beat(5'd10, 5'd11));
        send_item(query_beat(5'd10, 5'd12));
        send_item(query_beat(5'd11, 5'd12));
    endtask

    task automatic test_field_extremes();
        send_item(load_beat(5'd31, 10'd1023, CHAR_T));
        send_item(load_beat(5'd0, 10'd1023, CHAR_G));
        for (int p = 0; p < 4; p++)
            send_item(load_beat(5'd31, POS_W'(p), rand_base()));
        set_counter_mode(MODEL_MISMATCH, 11'd4);
        send_item(query_beat(5'd0, 5'd31));
        send_item(query_beat(5'd31, 5'd0));
        // A length above the sequence length NLEN saturates to the full sequence.
        set_counter_mode(MODEL_MISMATCH, LEN_OVER);
        send_item(query_beat(5'd0, 5'd0));
        send_item(query_beat(5'd31, 5'd31));
    endtask

    task automatic test_models();
        set_counter_mode(MODEL_MISMATCH, 11'd4);
        send_item(query_beat(5'd10, 5'd11));
        set_counter_mode(MODEL_NONE, 11'd4);
        send_item(query_beat(5'd10, 5'd11));
        send_item(query_beat(5'd10, 5'd10));
        set_counter_mode(MODEL_UNUSED, 11'd4);
        send_item(query_beat(5'd10, 5'd11));
    endtask

    task automatic test_lengths();
        set_counter_mode(MODEL_TSTV, 11'd0);
        send_item(query_beat(5'd10, 5'd11));
        send_item(query_beat(5'd31, 5'd31));
        set_counter_mode(MODEL_TSTV, LEN_RESET);
        send_item(query_beat(5'd0, 5'd0));
        set_counter_mode(MODEL_NONE, LEN_RESET);
        send_item(query_beat(5'd31, 5'd0));
    endtask

    task automatic test_backpressure();
        set_counter_mode(MODEL_TSTV, 11'd8);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_len   = 300;
        hold_token++;
        for (int i = 0; i < 12; i++)
            send_item(query_beat(pick_seq(), pick_seq()));
        wait_results_done();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < 4; i++)
            send_item(query_beat(pick_seq(), pick_seq()));
        wait_results_done();
        for (int i = 0; i < 4; i++)
            send_item(query_beat(pick_seq(), pick_seq()));
    endtask

    task automatic run_random_phase(logic [MODEL_W-1:0] model, logic [CNT_W-1:0] len, int count);
        int               span;
        logic [SEQ_W-1:0] s1;
        logic [SEQ_W-1:0] s2;
        logic [POS_W-1:0] pos;
        set_counter_mode(model, len);
        span = (len == 0 || len > NLEN) ? NLEN : int'(len);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 9) == 0)
                    pos = POS_W'($urandom_range(0, NLEN - 1));
                else
                    pos = POS_W'($urandom_range(0, span - 1));
                send_item(load_beat(pick_seq(), pos, rand_base()));
            end else begin
                s1 = pick_seq();
                s2 = ($urandom_range(0, 6) == 0) ? s1 : pick_seq();
                send_item(query_beat(s1, s2));
            end
        end
    endtask

    task automatic test_random_mix();
        run_random_phase(MODEL_TSTV, 11'd16, 120);
        run_random_phase(MODEL_MISMATCH, 11'd5, 80);
        run_random_phase(MODEL_NONE, 11'd64, 40);
        run_random_phase(MODEL_UNUSED, 11'd1, 40);
        run_random_phase(MODEL_TSTV, LEN_RESET, 15);
        run_random_phase(MODEL_MISMATCH, LEN_OVER, 15);
        run_random_phase(MODEL_TSTV, 11'd0, 30);
        run_random_phase(MODEL_MISMATCH, 11'd12, 60);
    endtask

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    // Result side: each accepted beat is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_beat
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_got++;
            if (pending_counts.size() == 0) begin
                n_errors++;
                $display("%0t: result beat with none expected, actual %h", $time, o_out_item);
            end else begin
                want = pending_counts.pop_front();
                check_field("first_seq", int'(want.first_seq), int'(o_out_item.first_seq));
                check_field("second_seq", int'(want.second_seq), int'(o_out_item.second_seq));
                check_field("common_count", int'(want.common_count),
                            int'(o_out_item.common_count));
                check_field("first_count", int'(want.first_count),
                            int'(o_out_item.first_count));
                check_field("second_count", int'(want.second_count),
                            int'(o_out_item.second_count));
            end
        end
    end

    // Receiver: a random pause after each beat when enabled, plus a long hold-off on request.
    initial begin : result_sink
        int acked;
        int gap;
        int hold_left;
        int token_seen;
        acked       = 0;
        gap         = 0;
        hold_left   = 0;
        token_seen  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_token != token_seen) begin
                token_seen = hold_token;
                hold_left  = hold_len;
            end
            if (results_got != acked) begin
                acked = results_got;
                gap   = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (i_in_valid && !o_in_ready)
            stall_cycles++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, pending_counts.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_IDX_MODEL;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        model_reg   = MODEL_RESET;
        len_reg     = LEN_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_prefill();
        test_base_codes();
        test_field_extremes();
        test_models();
        test_lengths();
        test_backpressure();
        test_random_mix();
        wait_results_done();

        $display("Covered %0d loads and %0d pair queries over %0d register settings,",
                 loads_sent, queries_sent, settings_used);
        $display("with the input held off for %0d cycles by a full pipeline.", stall_cycles);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ dna_pair_mutation_counter.f @@
rtl/core/dpmc_pkg.sv
rtl/core/dpmc_ram.sv
rtl/core/dpmc_front.sv
rtl/core/dpmc_queue.sv
rtl/core/dpmc_back.sv
rtl/core/dna_pair_mutation_counter.sv
verif/tb_top.sv
